// ===== hdl/pets_pkg.sv =====
// Shared types and codes for the priority event task scheduler.
package pets_pkg;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_SET   = 2'd1,
    MODE_CLR   = 2'd2,
    MODE_QUERY = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_BAD_ID = 2'd1,
    STAT_FULL   = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    mode_t       mode;
    logic [3:0]  task_id;
    logic [15:0] event_flags;
    logic [7:0]  priority_req;
  } in_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  new_task_id;
    logic        ready_valid;
    logic [3:0]  ready_task_id;
    logic [15:0] ready_events;
  } out_t;

  // Command broadcast to every cell; each cell also gets its own select.
  typedef struct packed {
    logic        add;
    logic        set;
    logic        clr;
    logic [7:0]  prio;
    logic [15:0] flags;
  } cell_cmd_t;

  // Best candidate so far, handed from cell to cell.
  typedef struct packed {
    logic        found;
    logic [7:0]  prio;
    logic [3:0]  id;
    logic [15:0] events;
  } cand_t;

endpackage

// ===== hdl/priority_event_task_scheduler.sv =====
// Top level: task table as a chain of cells with a per-item ready search.
// The candidate passes one cell per cycle down the chain. A new beat is
//   taken only back in idle, after the result has gone into the output
//   register; that move waits while the register is full and not read.
// Reset (rst_n, synchronous): task count and all event masks cleared,
//   no result pending; priorities are left as they are until written.
module priority_event_task_scheduler #(
  parameter int MAX_TASKS  = 16,
  parameter int EVENT_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  pets_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output pets_pkg::out_t   out_data
);

  // Count width holds MAX_TASKS itself; compares run at least 4 bits wide
  // so a task id is never truncated.
  localparam int CW   = $clog2(MAX_TASKS + 1);
  localparam int CMPW = (CW > 4) ? CW : 4;

  pets_pkg::state_t    state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       scan_r, scan_nxt;
  pets_pkg::status_t   stat_r;
  logic [3:0]          new_id_r;
  logic                out_valid_r, out_valid_nxt;
  pets_pkg::out_t      out_r;

  logic                accept;
  logic                scan_done;
  logic                load;
  logic [CMPW-1:0]     tid_x;
  logic [CMPW-1:0]     cnt_x;
  logic [CMPW-1:0]     tgt_x;
  logic                add_ok;
  logic                id_ok;
  pets_pkg::status_t   stat_now;
  pets_pkg::cell_cmd_t cmd;

  pets_pkg::cand_t     chain [MAX_TASKS+1];

  assign accept    = in_valid && in_ready;
  assign scan_done = (scan_r == CW'(MAX_TASKS));
  // Result moves into the output register once the last cell has seen the
  // updated table and the register is free (or being emptied this cycle).
  assign load      = (state_r == pets_pkg::ST_SCAN) && scan_done &&
                     (!out_valid_r || out_ready);

  assign tid_x  = CMPW'(in_data.task_id);
  assign cnt_x  = CMPW'(count_r);
  assign add_ok = (count_r != CW'(MAX_TASKS));
  assign id_ok  = (tid_x < cnt_x);

  // Decode the beat: command to the cells, status for the result.
  always_comb begin
    cmd       = '0;
    cmd.prio  = in_data.priority_req;
    cmd.flags = in_data.event_flags;
    tgt_x     = tid_x;
    stat_now  = pets_pkg::STAT_OK;
    unique case (in_data.mode)
      pets_pkg::MODE_ADD: begin
        tgt_x    = cnt_x;
        cmd.add  = accept && add_ok;
        stat_now = add_ok ? pets_pkg::STAT_OK : pets_pkg::STAT_FULL;
      end
      pets_pkg::MODE_SET: begin
        cmd.set  = accept && id_ok;
        stat_now = id_ok ? pets_pkg::STAT_OK : pets_pkg::STAT_BAD_ID;
      end
      pets_pkg::MODE_CLR: begin
        cmd.clr  = accept && id_ok;
        stat_now = id_ok ? pets_pkg::STAT_OK : pets_pkg::STAT_BAD_ID;
      end
      pets_pkg::MODE_QUERY: begin
        stat_now = pets_pkg::STAT_OK;
      end
      default: begin
        stat_now = pets_pkg::STAT_OK;
      end
    endcase
  end

  // Cell chain; the head sees "nothing found", the tail holds the winner.
  assign chain[0] = '0;

  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    logic sel;
    assign sel = (tgt_x == CMPW'(i));
    pets_cell #(
      .IDX        (i),
      .EVENT_BITS (EVENT_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .sel      (sel),
      .cand_in  (chain[i]),
      .cand_out (chain[i+1])
    );
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pets_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = pets_pkg::ST_SCAN;
        end
      end
      pets_pkg::ST_SCAN: begin
        if (load) begin
          state_nxt = pets_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pets_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs and datapath control
  always_comb begin
    in_ready      = (state_r == pets_pkg::ST_IDLE);
    count_nxt     = count_r;
    scan_nxt      = scan_r;
    out_valid_nxt = out_valid_r;
    if (accept) begin
      scan_nxt = '0;
      if (cmd.add) begin
        count_nxt = count_r + CW'(1);
      end
    end else if ((state_r == pets_pkg::ST_SCAN) && !scan_done) begin
      scan_nxt = scan_r + CW'(1);
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pets_pkg::ST_IDLE;
      count_r     <= '0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Per-item result fields, captured with the beat.
  always_ff @(posedge clk) begin
    if (accept) begin
      stat_r   <= stat_now;
      new_id_r <= cmd.add ? 4'(count_r) : 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r.status        <= stat_r;
      out_r.new_task_id   <= new_id_r;
      out_r.ready_valid   <= chain[MAX_TASKS].found;
      out_r.ready_task_id <= chain[MAX_TASKS].id;
      out_r.ready_events  <= chain[MAX_TASKS].events;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hdl/pets_cell.sv =====
// One task slot: priority, event mask and one stage of the ready search.
module pets_cell #(
  parameter int IDX        = 0,
  parameter int EVENT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pets_pkg::cell_cmd_t cmd,
  input  logic               sel,
  input  pets_pkg::cand_t    cand_in,
  output pets_pkg::cand_t    cand_out
);

  localparam logic [3:0] ID = 4'(IDX);

  logic [7:0]            prio_r;
  logic [EVENT_BITS-1:0] ev_r;
  logic [EVENT_BITS-1:0] ev_nxt;
  logic [EVENT_BITS-1:0] flags_m;
  pets_pkg::cand_t       cand_r;
  pets_pkg::cand_t       cand_nxt;
  logic                  take;

  assign flags_m = EVENT_BITS'(cmd.flags);

  always_comb begin
    ev_nxt = ev_r;
    if (sel) begin
      priority if (cmd.add) begin
        ev_nxt = '0;
      end else if (cmd.set) begin
        ev_nxt = ev_r | flags_m;
      end else if (cmd.clr) begin
        ev_nxt = ev_r & ~flags_m;
      end else begin
        ev_nxt = ev_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel && cmd.add) begin
      prio_r <= cmd.prio;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_r <= '0;
    end else begin
      ev_r <= ev_nxt;
    end
  end

  // Strictly greater: an earlier cell keeps a tie.
  assign take = (ev_r != '0) && (!cand_in.found || (prio_r > cand_in.prio));

  always_comb begin
    cand_nxt = cand_in;
    if (take) begin
      cand_nxt.found  = 1'b1;
      cand_nxt.prio   = prio_r;
      cand_nxt.id     = ID;
      cand_nxt.events = 16'(ev_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r <= '0;
    end else begin
      cand_r <= cand_nxt;
    end
  end

  assign cand_out = cand_r;

endmodule

// ===== bench/pets_checker.sv =====
// Checker: predicts scheduler results from accepted beats and compares them.
module pets_checker #(
  parameter int NTASK = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_ready,
  input  pets_pkg::in_t   in_data,
  input  logic            out_valid,
  input  logic            out_ready,
  input  pets_pkg::out_t  out_data,
  output int              due_count,
  output int              fail_count
);

  // Shadow task table.
  int          n_tasks;
  logic [7:0]  prio_tab [NTASK];
  logic [15:0] ev_tab   [NTASK];

  pets_pkg::out_t ready_reports_due [$];
  int             errs;

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    errs++;
    $display("mismatch %s: got %0h, want %0h", what, got, want);
  endtask

  // Apply one item to the shadow table and work out its result beat.
  function automatic pets_pkg::out_t advance_table(input pets_pkg::in_t it);
    pets_pkg::out_t r;
    logic           found;
    logic [7:0]     best_prio;
    int             i;
    r = '0;
    r.status = pets_pkg::STAT_OK;
    case (it.mode)
      pets_pkg::MODE_ADD: begin
        if (n_tasks >= NTASK) begin
          r.status = pets_pkg::STAT_FULL;
        end else begin
          r.new_task_id     = 4'(n_tasks);
          prio_tab[n_tasks] = it.priority_req;
          ev_tab[n_tasks]   = '0;
          n_tasks++;
        end
      end
      pets_pkg::MODE_SET, pets_pkg::MODE_CLR: begin
        if (it.task_id >= n_tasks) begin
          r.status = pets_pkg::STAT_BAD_ID;
        end else if (it.mode == pets_pkg::MODE_SET) begin
          ev_tab[it.task_id] = ev_tab[it.task_id] | it.event_flags;
        end else begin
          ev_tab[it.task_id] = ev_tab[it.task_id] & ~it.event_flags;
        end
      end
      default: ;
    endcase
    // strict compare: earlier task keeps a tie
    found     = 1'b0;
    best_prio = '0;
    for (i = 0; i < n_tasks; i++) begin
      if (ev_tab[i] != '0 && (!found || prio_tab[i] > best_prio)) begin
        found           = 1'b1;
        best_prio       = prio_tab[i];
        r.ready_valid   = 1'b1;
        r.ready_task_id = 4'(i);
        r.ready_events  = ev_tab[i];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    pets_pkg::out_t want;
    if (!rst_n) begin
      n_tasks = 0;
      foreach (ev_tab[i]) ev_tab[i] = '0;
      ready_reports_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (ready_reports_due.size() == 0) begin
          note_mismatch("result beat with nothing due", 32'(out_data), '0);
        end else begin
          want = ready_reports_due.pop_front();
          if (out_data.status !== want.status)
            note_mismatch("status", 32'(out_data.status), 32'(want.status));
          if (out_data.new_task_id !== want.new_task_id)
            note_mismatch("new_task_id", 32'(out_data.new_task_id), 32'(want.new_task_id));
          if (out_data.ready_valid !== want.ready_valid)
            note_mismatch("ready_valid", 32'(out_data.ready_valid), 32'(want.ready_valid));
          if (out_data.ready_task_id !== want.ready_task_id)
            note_mismatch("ready_task_id", 32'(out_data.ready_task_id),
                          32'(want.ready_task_id));
          if (out_data.ready_events !== want.ready_events)
            note_mismatch("ready_events", 32'(out_data.ready_events),
                          32'(want.ready_events));
        end
      end
      if (in_valid && in_ready)
        ready_reports_due.push_back(advance_table(in_data));
    end
    due_count  <= ready_reports_due.size();
    fail_count <= errs;
  end

endmodule

// ===== bench/tb.sv =====
// Testbench top: stimulus, handshake pacing and verdict for the scheduler.
module tb;

  localparam int NTASK       = 16;
  localparam int LAT         = NTASK + 1;   // input beat to result beat
  localparam int PHASE_ITEMS = 320;
  localparam int HOLD_CYCLES = 300;         // long receiver hold-off
  localparam int DRAIN_LIMIT = 20000;

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_ready;
  pets_pkg::in_t  in_data   = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  pets_pkg::out_t out_data;
  int             due_count;
  int             fail_count;

  // Pacing knobs. tx_idle_pct is only touched by the stimulus process;
  // rx_stall_pct and hold_reqs are read by the receiver, so they change by NBA.
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_reqs    = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int adds_issued  = 0;   // adds sent so far, capped at the table size

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  priority_event_task_scheduler #(
    .MAX_TASKS  (NTASK),
    .EVENT_BITS (16)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  pets_checker #(
    .NTASK (NTASK)
  ) u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .due_count  (due_count),
    .fail_count (fail_count)
  );

  // Receiver: random stalls, plus a long hold-off on request. The hold is
  // counted here so the sender keeps offering beats while the block backs up.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_reqs) begin
      out_ready <= 1'b0;
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  function automatic pets_pkg::in_t beat_of(input pets_pkg::mode_t m,
                                            input logic [3:0] id,
                                            input logic [15:0] flags,
                                            input logic [7:0] prio);
    pets_pkg::in_t it;
    it.mode         = m;
    it.task_id      = id;
    it.event_flags  = flags;
    it.priority_req = prio;
    return it;
  endfunction

  // Random operation. Mostly well-formed: set/clear aim at tasks that exist,
  // event masks lean sparse or all-ones so tasks drain back to idle often.
  function automatic pets_pkg::in_t next_op();
    pets_pkg::in_t it;
    int            pick;
    it.task_id      = 4'($urandom_range(0, 15));
    it.event_flags  = 16'($urandom);
    it.priority_req = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 8)       it.mode = pets_pkg::MODE_ADD;
    else if (pick < 43) it.mode = pets_pkg::MODE_SET;
    else if (pick < 85) it.mode = pets_pkg::MODE_CLR;
    else                it.mode = pets_pkg::MODE_QUERY;

    if (it.mode == pets_pkg::MODE_ADD) begin
      // a narrow set of priorities gives plenty of ties
      if ($urandom_range(0, 9) < 4) begin
        case ($urandom_range(0, 3))
          0:       it.priority_req = 8'h00;
          1:       it.priority_req = 8'hFF;
          2:       it.priority_req = 8'h80;
          default: it.priority_req = 8'h7F;
        endcase
      end
    end else if (it.mode != pets_pkg::MODE_QUERY) begin
      if (adds_issued > 0 && $urandom_range(0, 99) < 85)
        it.task_id = 4'($urandom_range(0, adds_issued - 1));
      pick = $urandom_range(0, 9);
      if (pick == 0)
        it.event_flags = 16'h0;
      else if (pick < 3 || (pick < 6 && it.mode == pets_pkg::MODE_CLR))
        it.event_flags = 16'hFFFF;
      else if (pick < 6)
        it.event_flags = 16'h1 << $urandom_range(0, 15);
      else if (pick < 8)
        it.event_flags = 16'($urandom) & 16'($urandom) & 16'($urandom);
    end
    return it;
  endfunction

  // One input beat. Any idle gap comes first so valid is never dropped and
  // raised in the same step; once up, valid holds until the beat goes in.
  task automatic send_beat(input pets_pkg::in_t item);
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    if (item.mode == pets_pkg::MODE_ADD && adds_issued < NTASK) adds_issued++;
    do begin
      @(posedge clk);
    end while (!in_ready);
  endtask

  // Sender drops valid and stands still until every due result has come back or the drain limit is reached.
  task automatic wait_drained();
    int spins;
    spins = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      spins++;
    end while (due_count != 0 && spins < DRAIN_LIMIT);
  endtask

  initial begin
    int ph;
    int n;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, unknown ids, adds with extreme and tied
    // priorities, ignored fields, tie-break on equal priority, partial and
    // full clears, and the nothing-ready case again at the end.
    send_beat(beat_of(pets_pkg::MODE_QUERY, 4'hF, 16'hFFFF, 8'hFF));
    send_beat(beat_of(pets_pkg::MODE_SET,   4'h0, 16'hFFFF, 8'h00));
    send_beat(beat_of(pets_pkg::MODE_CLR,   4'hF, 16'hFFFF, 8'hFF));
    send_beat(beat_of(pets_pkg::MODE_ADD,   4'hF, 16'hFFFF, 8'h00));
    send_beat(beat_of(pets_pkg::MODE_ADD,   4'h0, 16'h0000, 8'hFF));
    send_beat(beat_of(pets_pkg::MODE_ADD,   4'h5, 16'h1234, 8'hFF));
    send_beat(beat_of(pets_pkg::MODE_ADD,   4'h0, 16'h0000, 8'h80));
    send_beat(beat_of(pets_pkg::MODE_SET,   4'h4, 16'hFFFF, 8'h00));
    send_beat(beat_of(pets_pkg::MODE_SET,   4'h0, 16'h0001, 8'hFF));
    send_beat(beat_of(pets_pkg::MODE_SET,   4'h3, 16'h8000, 8'h00));
    send_beat(beat_of(pets_pkg::MODE_SET,   4'h2, 16'hFFFF, 8'h00));
    send_beat(beat_of(pets_pkg::MODE_SET,   4'h1, 16'hA5A5, 8'h5A));
    send_beat(beat_of(pets_pkg::MODE_CLR,   4'h1, 16'hFFFF, 8'hFF));
    send_beat(beat_of(pets_pkg::MODE_SET,   4'h2, 16'h0000, 8'h00));
    send_beat(beat_of(pets_pkg::MODE_CLR,   4'h2, 16'h5555, 8'h00));
    send_beat(beat_of(pets_pkg::MODE_CLR,   4'h2, 16'hFFFF, 8'h00));
    send_beat(beat_of(pets_pkg::MODE_CLR,   4'h3, 16'hFFFF, 8'h00));
    send_beat(beat_of(pets_pkg::MODE_CLR,   4'h0, 16'h0001, 8'h00));
    send_beat(beat_of(pets_pkg::MODE_QUERY, 4'h0, 16'h0000, 8'h00));
    send_beat(beat_of(pets_pkg::MODE_CLR,   4'h3, 16'h0000, 8'hFF));
    wait_drained();

    // Random phases: free-running, idle sender, stalling receiver, both.
    // The table fills early in the first phase; full-table adds follow.
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
        1:       begin tx_idle_pct = 78; rx_stall_pct <= 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct <= 78; end
        default: begin tx_idle_pct = 13; rx_stall_pct <= 13; end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // long hold-off: input backs up behind the parked result
        if (ph == 0 && n == 40) hold_reqs <= hold_reqs + 1;
        send_beat(next_op());
      end
      wait_drained();
    end

    wait_drained();
    repeat (3 * LAT) @(posedge clk);
    if (due_count != 0) $display("%0d results never arrived", due_count);
    if (fail_count == 0 && due_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
